// File: hw/rtl/occupancy_grid_dilation_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the occupancy grid dilation core
// Concurrent checks that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef OCCUPANCY_GRID_DILATION_CORE_MACROS_SVH
`define OCCUPANCY_GRID_DILATION_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define OGD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("ogd assertion failed");
`define OGD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ogd assertion failed");
`else
`define OGD_ASSERT(label, clk, rst_n, prop)
`define OGD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/ogd_pkg.sv
// ---------------------------------------------------------------------------
// Occupancy grid dilation package
// Cell class codes, register indexes and a shared control type.
// ---------------------------------------------------------------------------
package ogd_pkg;

    localparam int ROW_W      = 11;
    localparam int CFG_W      = 11;
    localparam int MAX_HEIGHT = 1024;

    localparam logic [ROW_W-1:0] ROW_SAT = 11'h7FF;

    localparam logic [1:0] CLS_FREE     = 2'd0;
    localparam logic [1:0] CLS_OCCUPIED = 2'd1;
    localparam logic [1:0] CLS_UNKNOWN  = 2'd2;
    localparam logic [1:0] CLS_FLUSH    = 2'd3;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    // control handed to the column window
    typedef struct packed {
        logic shift;
        logic clear;
        logic occ_flag;
        logic free_flag;
    } win_ctrl_t;

endpackage

// File: hw/rtl/ogd_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle; read returns old data.
// ---------------------------------------------------------------------------
module ogd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: hw/rtl/ogd_window.sv
// ---------------------------------------------------------------------------
// Column window
// Shift registers of column flags and the clipped horizontal reduction.
// ---------------------------------------------------------------------------
module ogd_window import ogd_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  win_ctrl_t                         ctrl,
    input  logic [$clog2(MAX_WIDTH)-1:0]      emit_col,
    input  logic [$clog2(MAX_RADIUS+1)-1:0]   radius,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]    width,
    output logic [1:0]                        class_next
);
    localparam int WIN_LEN = 2 * MAX_RADIUS + 1;

    logic [WIN_LEN-1:0] occ_win_reg, occ_win_next, occ_shift;
    logic [WIN_LEN-1:0] free_win_reg, free_win_next, free_shift;
    logic [WIN_LEN-1:0] mask;
    logic               any_occ, any_free;

    assign occ_shift  = {occ_win_reg[WIN_LEN-2:0], ctrl.occ_flag};
    assign free_shift = {free_win_reg[WIN_LEN-2:0], ctrl.free_flag};

    // tap k is the cell R-k columns right of the emitted one
    always_comb begin
        for (int k = 0; k < WIN_LEN; k++) begin
            mask[k] = (k <= 2 * int'(radius))
                   && (k <= int'(emit_col) + int'(radius))
                   && (k + int'(width) > int'(emit_col) + int'(radius));
        end
    end

    assign any_occ    = |(occ_shift & mask);
    assign any_free   = |(free_shift & mask);
    assign class_next = any_occ ? CLS_OCCUPIED : (any_free ? CLS_FREE : CLS_UNKNOWN);

    always_comb begin
        occ_win_next  = occ_win_reg;
        free_win_next = free_win_reg;
        if (ctrl.clear) begin
            occ_win_next  = '0;
            free_win_next = '0;
        end else if (ctrl.shift) begin
            occ_win_next  = occ_shift;
            free_win_next = free_shift;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_win_reg  <= '0;
            free_win_reg <= '0;
        end else begin
            occ_win_reg  <= occ_win_next;
            free_win_reg <= free_win_next;
        end
    end
endmodule

// File: hw/rtl/occupancy_grid_dilation_core.sv
// ---------------------------------------------------------------------------
// Occupancy grid dilation core
// Output: m_tvalid comes from the output register, set by an accept that emits; the stream lags by R rows plus R cells.
// Throughput: one word per cycle; a result word held by m_tready stalls s_tready.
// Reset: aresetn (synchronous, active low) restores registers and clears all
// stream state; no RAM clearing pass is needed.
// ---------------------------------------------------------------------------
`include "occupancy_grid_dilation_core_macros.svh"

module occupancy_grid_dilation_core import ogd_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration write port
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,
    // input cell stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [1:0] cell_class, [7:2] zero
    // inflated cell stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // [1:0] out_class, [11:2] out_row,
                                         // [21:12] out_col, [23:22] zero
    output logic              m_tlast    // frame_last
);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WID_W   = $clog2(MAX_WIDTH + 1);
    localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
    localparam int AGE_SAT = 2 * MAX_RADIUS + 1;
    localparam int AGE_W   = $clog2(AGE_SAT + 1);
    localparam int LAG_W   = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);

    // Configuration registers, raw as written
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [3:0]       radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W'(1024);
            height_reg <= CFG_W'(1024);
            radius_reg <= 4'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_wdata;
                REG_HEIGHT: height_reg <= cfg_wdata;
                REG_RADIUS: radius_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    logic cfg_clear;
    assign cfg_clear = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT
                                  || cfg_index == REG_RADIUS);

    // Effective (clamped) geometry
    logic [WID_W-1:0] eff_w;
    logic [CFG_W-1:0] eff_h;
    logic [RAD_W-1:0] eff_r;
    logic [LAG_W-1:0] lag_limit;

    always_comb begin
        if (width_reg == '0) eff_w = WID_W'(1);
        else if (32'(width_reg) > MAX_WIDTH) eff_w = WID_W'(MAX_WIDTH);
        else eff_w = WID_W'(width_reg);
        if (height_reg == '0) eff_h = CFG_W'(1);
        else if (32'(height_reg) > MAX_HEIGHT) eff_h = CFG_W'(MAX_HEIGHT);
        else eff_h = height_reg;
        if (32'(radius_reg) > MAX_RADIUS) eff_r = RAD_W'(MAX_RADIUS);
        else eff_r = RAD_W'(radius_reg);
    end

    assign lag_limit = LAG_W'(32'(eff_r) * 32'(eff_w) + 32'(eff_r));

    // Handshake: take a word whenever the output register is free or draining
    logic out_valid_reg, out_valid_next;
    logic accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Stream position state
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] em_row_reg, em_row_next;
    logic [COL_W-1:0] em_col_reg, em_col_next;
    logic [LAG_W-1:0] lag_reg, lag_next;

    // Line-age RAM: {free age, occupied age} per column
    logic [2*AGE_W-1:0] ram_q, ram_wdata;
    logic               fwd_valid_reg, fwd_valid_next;
    logic [2*AGE_W-1:0] fwd_data_reg;

    ogd_ram #(
        .WIDTH(2 * AGE_W),
        .DEPTH(MAX_WIDTH)
    ) u_age_ram (
        .aclk  (aclk),
        .we    (accept),
        .waddr (in_col_reg),
        .wdata (ram_wdata),
        .raddr (in_col_next),
        .rdata (ram_q)
    );

    // Row zero of a grid has never written its column: read as never seen
    logic [2*AGE_W-1:0] age_old;
    logic [AGE_W-1:0]   occ_age_old, free_age_old, occ_age_new, free_age_new;
    logic               in_grid, occ_hit, free_hit, vo, vf;
    logic [1:0]         cls;

    assign cls     = s_tdata[1:0];
    assign in_grid = in_row_reg < eff_h;
    assign occ_hit = in_grid && cls == CLS_OCCUPIED;
    assign free_hit = in_grid && cls == CLS_FREE;

    always_comb begin
        if (in_row_reg == '0) age_old = {AGE_W'(AGE_SAT), AGE_W'(AGE_SAT)};
        else if (fwd_valid_reg) age_old = fwd_data_reg;
        else age_old = ram_q;
    end

    assign occ_age_old  = age_old[AGE_W-1:0];
    assign free_age_old = age_old[2*AGE_W-1:AGE_W];

    // reset age on a hit, else count up and saturate
    assign occ_age_new  = occ_hit ? '0 : (32'(occ_age_old) >= AGE_SAT ? AGE_W'(AGE_SAT)
                                          : occ_age_old + AGE_W'(1));
    assign free_age_new = free_hit ? '0 : (32'(free_age_old) >= AGE_SAT ? AGE_W'(AGE_SAT)
                                           : free_age_old + AGE_W'(1));
    assign ram_wdata = {free_age_new, occ_age_new};
    assign vo = 32'(occ_age_new) <= 2 * 32'(eff_r);
    assign vf = 32'(free_age_new) <= 2 * 32'(eff_r);

    // Emission decision
    logic       emit, last, frame_clear;
    logic [1:0] class_next;
    win_ctrl_t  win_ctrl;

    assign emit = accept && (lag_reg >= lag_limit);
    assign last = (em_row_reg == eff_h - CFG_W'(1))
               && (32'(em_col_reg) == 32'(eff_w) - 1);
    assign frame_clear = emit && last;

    assign win_ctrl.shift     = accept;
    assign win_ctrl.clear     = frame_clear || cfg_clear;
    assign win_ctrl.occ_flag  = vo;
    assign win_ctrl.free_flag = vf;

    ogd_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (win_ctrl),
        .emit_col   (em_col_reg),
        .radius     (eff_r),
        .width      (eff_w),
        .class_next (class_next)
    );

    // Advance positions; drop back to a fresh grid on frame end or register write
    always_comb begin
        in_row_next    = in_row_reg;
        in_col_next    = in_col_reg;
        em_row_next    = em_row_reg;
        em_col_next    = em_col_reg;
        lag_next       = lag_reg;
        fwd_valid_next = 1'b0;
        if (accept) begin
            if (32'(in_col_reg) + 1 >= 32'(eff_w)) begin
                in_col_next = '0;
                if (in_row_reg != ROW_SAT) in_row_next = in_row_reg + ROW_W'(1);
            end else begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (!emit) begin
                lag_next = lag_reg + LAG_W'(1);
            end else if (32'(em_col_reg) + 1 >= 32'(eff_w)) begin
                em_col_next = '0;
                if (em_row_reg != ROW_SAT) em_row_next = em_row_reg + ROW_W'(1);
            end else begin
                em_col_next = em_col_reg + COL_W'(1);
            end
            fwd_valid_next = (in_col_next == in_col_reg);
        end
        if (frame_clear || cfg_clear) begin
            in_row_next    = '0;
            in_col_next    = '0;
            em_row_next    = '0;
            em_col_next    = '0;
            lag_next       = '0;
            fwd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            em_row_reg    <= '0;
            em_col_reg    <= '0;
            lag_reg       <= '0;
            fwd_valid_reg <= 1'b0;
        end else begin
            in_row_reg    <= in_row_next;
            in_col_reg    <= in_col_next;
            em_row_reg    <= em_row_next;
            em_col_reg    <= em_col_next;
            lag_reg       <= lag_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    // hold the word just written for a same-column read next cycle
    always_ff @(posedge aclk) begin
        fwd_data_reg <= ram_wdata;
    end

    // Output register
    logic [23:0] out_data_reg;
    logic        out_last_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) out_valid_next = 1'b0;
        if (emit) out_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_data_reg <= {2'b00, 10'(em_col_reg), em_row_reg[9:0], class_next};
            out_last_reg <= last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Checks
    `OGD_ASSERT(a_ready_when_empty, aclk, aresetn, !out_valid_reg |-> s_tready)
    `OGD_ASSERT(a_class_legal, aclk, aresetn, m_tvalid |-> m_tdata[1:0] != CLS_FLUSH)
    `OGD_ASSERT_NEXT(a_frame_restart, aclk, aresetn, frame_clear,
                     in_row_reg == '0 && lag_reg == '0 && em_col_reg == '0)
endmodule
